### hdl/byte_run_length_encoder_assert.svh
// assertion macros for the byte run-length encoder
// used by the top level only; expects clk and arst_n in scope
`ifndef BYTE_RUN_LENGTH_ENCODER_ASSERT_SVH
`define BYTE_RUN_LENGTH_ENCODER_ASSERT_SVH

// condition holds in the same cycle
`define BRLE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define BRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/brle_pkg.sv
// types and constants shared by the byte run-length encoder modules
// no dependencies
`default_nettype none

package brle_pkg;

	localparam logic [7:0] RunMax = 8'd255;

	typedef struct packed {
		logic [7:0] run_value;
		logic [7:0] run_extra;
		logic       final_pair;
	} pair_t;

	// one queue entry: one or two pairs caused by one input byte
	typedef struct packed {
		logic  two;
		pair_t first;
		pair_t second;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

### hdl/brle_in_if.sv
// input byte channel of the byte run-length encoder
// no dependencies
`default_nettype none

interface brle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

### hdl/brle_out_if.sv
// output pair channel of the byte run-length encoder
// no dependencies
`default_nettype none

interface brle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] run_value;
	logic [7:0] run_extra;
	logic       final_pair;

	modport source (output valid, output run_value, output run_extra, output final_pair,
		input ready);
	modport sink (input valid, input run_value, input run_extra, input final_pair,
		output ready);
endinterface

`default_nettype wire

### hdl/byte_run_length_encoder.sv
// byte run-length encoder, top level
// depends on brle_pkg, brle_in_if, brle_out_if, brle_front, brle_queue, brle_back
//
// byte_in carries one raw byte per word with end_of_buffer on the last byte
// of a buffer; run_out carries pairs (run_value, run_extra = length - 1) with
// final_pair set on the pair that closes the buffer. both use valid/ready.
// a byte can be taken every cycle; byte_in.ready only drops when the command
// queue (QUEUE_DEPTH entries) is full.
// the front end decides per byte whether zero, one or two pairs leave; the
// back end sends one pair per cycle while run_out is ready, from a registered
// output; the pair of a byte that closes a run goes through the queue, then
// the output register. sustained rate is one byte per cycle, bounded by the
// back end at one pair per cycle; a byte with two pairs sends them in turn.
// runs longer than 256 bytes are split into full pairs of extra 255.
// reset clears the open run, the queue and the output; the next byte starts a
// new buffer. when run_out stalls, pairs collect in the queue and then
// byte_in.ready goes low until the receiver takes words again.
`default_nettype none

`include "byte_run_length_encoder_assert.svh"

module byte_run_length_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	brle_in_if.sink    byte_in,
	brle_out_if.source run_out
);

	brle_pkg::cmd_t    cmd;
	brle_pkg::cmd_t    head;
	brle_pkg::q_stat_t q_stat;
	logic              cmd_push;
	logic              cmd_pop;

	brle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.q_stat   (q_stat),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	brle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (cmd_pop),
		.head     (head),
		.stat     (q_stat)
	);

	brle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (cmd_pop),
		.run_out (run_out)
	);

	`BRLE_ASSERT_SAME(a_no_push_full, cmd_push, !q_stat.full, "push into full queue")
	`BRLE_ASSERT_SAME(a_last_pushes,
		byte_in.valid && byte_in.ready && byte_in.end_of_buffer, cmd_push,
		"end of buffer produced no pair")
	`BRLE_ASSERT_SAME(a_two_final, !q_stat.empty && head.two,
		head.second.final_pair && !head.first.final_pair,
		"second pair of a command is not the final one")
	`BRLE_ASSERT_NEXT(a_pop_shows, cmd_pop, run_out.valid,
		"popped command did not reach the output")

endmodule

`default_nettype wire

### hdl/brle_front.sv
// front end: accepts bytes, tracks the open run, builds pair commands
// depends on brle_pkg and brle_in_if
`default_nettype none

module brle_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	brle_in_if.sink               byte_in,
	input  wire brle_pkg::q_stat_t q_stat,
	output logic                  cmd_push,
	output brle_pkg::cmd_t        cmd
);

	logic       run_open_q;
	logic [7:0] held_q;
	logic [7:0] count_q;

	logic           accept;
	logic           emit_close;
	brle_pkg::pair_t close_pair;
	brle_pkg::pair_t last_pair;
	logic [7:0]     held_next;
	logic [7:0]     count_next;

	assign byte_in.ready = !q_stat.full;
	assign accept = byte_in.valid && byte_in.ready;

	always_comb begin
		emit_close = 1'b0;
		close_pair = '{run_value: held_q, run_extra: count_q, final_pair: 1'b0};
		held_next  = held_q;
		count_next = count_q;
		priority if (!run_open_q) begin
			held_next  = byte_in.data_byte;
			count_next = '0;
		end else if (byte_in.data_byte == held_q) begin
			if (count_q == brle_pkg::RunMax) begin
				emit_close = 1'b1;
				count_next = '0;
			end else begin
				count_next = count_q + 8'd1;
			end
		end else begin
			emit_close = 1'b1;
			held_next  = byte_in.data_byte;
			count_next = '0;
		end
		last_pair = '{run_value: held_next, run_extra: count_next, final_pair: 1'b1};
		if (emit_close) begin
			cmd = '{two: byte_in.end_of_buffer, first: close_pair, second: last_pair};
		end else begin
			cmd = '{two: 1'b0, first: last_pair, second: last_pair};
		end
	end

	assign cmd_push = accept && (emit_close || byte_in.end_of_buffer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			held_q     <= '0;
			count_q    <= '0;
		end else if (accept) begin
			if (byte_in.end_of_buffer) begin
				run_open_q <= 1'b0;
				held_q     <= '0;
				count_q    <= '0;
			end else begin
				run_open_q <= 1'b1;
				held_q     <= held_next;
				count_q    <= count_next;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/brle_queue.sv
// command queue between front end and back end
// depends on brle_pkg
`default_nettype none

module brle_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire brle_pkg::cmd_t    push_cmd,
	input  wire logic              pop,
	output brle_pkg::cmd_t         head,
	output brle_pkg::q_stat_t      stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	brle_pkg::cmd_t mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CntW'(DEPTH));
	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/brle_back.sv
// back end: drains pair commands and drives the registered output
// depends on brle_pkg and brle_out_if
`default_nettype none

module brle_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire brle_pkg::cmd_t    head,
	input  wire brle_pkg::q_stat_t q_stat,
	output logic                   pop,
	brle_out_if.source             run_out
);

	logic            out_valid_q;
	brle_pkg::pair_t out_q;
	logic            pend_valid_q;
	brle_pkg::pair_t pend_q;
	logic            load;

	assign load = !out_valid_q || run_out.ready;
	assign pop  = load && !pend_valid_q && !q_stat.empty;

	assign run_out.valid      = out_valid_q;
	assign run_out.run_value  = out_q.run_value;
	assign run_out.run_extra  = out_q.run_extra;
	assign run_out.final_pair = out_q.final_pair;

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else begin
				out_q  <= head.first;
				pend_q <= head.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= !q_stat.empty;
				pend_valid_q <= !q_stat.empty && head.two;
			end
		end
	end

endmodule

`default_nettype wire
